>>> hdl/sawc_pkg.sv
// Shared types, constants and codes for the set-associative write-back cache.
package sawc_pkg;

  localparam int unsigned NumLines    = 256;
  localparam int unsigned LineWords   = 16;
  localparam int unsigned AddrBits    = 16;
  localparam int unsigned LineIdxBits = $clog2(NumLines);
  localparam int unsigned WordIdxBits = $clog2(LineWords);
  localparam int unsigned DataAddrBits = LineIdxBits + WordIdxBits;

  typedef enum logic [1:0] {
    CFG_LINE_WORDS_LOG2 = 2'd0,
    CFG_SET_COUNT_LOG2  = 2'd1,
    CFG_WAY_COUNT       = 2'd2,
    CFG_NONE            = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_FILL  = 2'd2,
    REQ_BAD   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ACT_RD_HIT   = 3'd0,
    ACT_WR_HIT   = 3'd1,
    ACT_FILL     = 3'd2,
    ACT_EV_DIRTY = 3'd3,
    ACT_EV_CLEAN = 3'd4,
    ACT_WB_WORD  = 3'd5,
    ACT_FILL_REQ = 3'd6,
    ACT_REFUSED  = 3'd7
  } act_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_REF, ST_FWR, ST_FEM2, ST_FEML, ST_BASE, ST_SRD, ST_SCMP,
    ST_VIC, ST_VTRD, ST_VEV, ST_WRD, ST_WEM, ST_UPD, ST_TRD, ST_TWR,
    ST_HOP, ST_HEM, ST_M6
  } state_e;

  // Control word from the sequencer to the line store.
  typedef struct packed {
    logic                    clr;
    logic [LineIdxBits-1:0]  line;
    logic                    tag_re;
    logic                    tag_we;
    logic [AddrBits-1:0]     tag_wd;
    logic                    rank_re;
    logic                    rank_we;
    logic [7:0]              rank_wd;
    logic                    data_re;
    logic                    data_we;
    logic [DataAddrBits-1:0] daddr;
    logic [31:0]             data_wd;
    logic                    valid_set;
    logic                    dirty_we;
    logic                    dirty_wd;
  } st_ctl_t;

  // Status returned by the line store.
  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic                rank_ok;
    logic [AddrBits-1:0] tag_rd;
    logic [7:0]          rank_rd;
    logic [31:0]         data_rd;
  } st_sts_t;

endpackage

>>> hdl/sawc_store.sv
// Line store: tag, rank and data memories plus valid, dirty and rank-valid flags.
module sawc_store import sawc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  st_ctl_t ctl_i,
  output st_sts_t sts_o
);

  logic [AddrBits-1:0] tag_mem  [NumLines];
  logic [7:0]          rank_mem [NumLines];
  logic [31:0]         data_mem [NumLines*LineWords];

  logic [NumLines-1:0] valid_q, dirty_q, rkv_q;
  logic [AddrBits-1:0] tag_rd_q;
  logic [7:0]          rank_rd_q;
  logic [31:0]         data_rd_q;

  // Tag memory with registered read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.tag_we) tag_mem[ctl_i.line] <= ctl_i.tag_wd;
    if (ctl_i.tag_re) tag_rd_q <= tag_mem[ctl_i.line];
  end

  // Rank memory with registered read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rank_we) rank_mem[ctl_i.line] <= ctl_i.rank_wd;
    if (ctl_i.rank_re) rank_rd_q <= rank_mem[ctl_i.line];
  end

  // Line data memory with registered read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.data_we) data_mem[ctl_i.daddr] <= ctl_i.data_wd;
    if (ctl_i.data_re) data_rd_q <= data_mem[ctl_i.daddr];
  end

  // Per-line flags; a rank whose flag is clear reads as its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      rkv_q   <= '0;
    end else if (ctl_i.clr) begin
      valid_q <= '0;
      dirty_q <= '0;
      rkv_q   <= '0;
    end else begin
      if (ctl_i.valid_set) valid_q[ctl_i.line] <= 1'b1;
      if (ctl_i.dirty_we)  dirty_q[ctl_i.line] <= ctl_i.dirty_wd;
      if (ctl_i.rank_we)   rkv_q[ctl_i.line]   <= 1'b1;
    end
  end

  assign sts_o.valid   = valid_q[ctl_i.line];
  assign sts_o.dirty   = dirty_q[ctl_i.line];
  assign sts_o.rank_ok = rkv_q[ctl_i.line];
  assign sts_o.tag_rd  = tag_rd_q;
  assign sts_o.rank_rd = rank_rd_q;
  assign sts_o.data_rd = data_rd_q;

endmodule

>>> hdl/sawc_way.sv
// Shared per-way unit: tag compare, effective rank and LRU rank update.
module sawc_way import sawc_pkg::*; (
  input  logic [AddrBits-1:0] tag_i,
  input  st_sts_t             sts_i,
  input  logic [7:0]          rst_rank_i,
  input  logic [7:0]          old_rank_i,
  input  logic [7:0]          top_rank_i,
  input  logic                is_target_i,
  output logic                hit_o,
  output logic [7:0]          rank_o,
  output logic [7:0]          rank_new_o
);

  assign rank_o = sts_i.rank_ok ? sts_i.rank_rd : rst_rank_i;
  assign hit_o  = sts_i.valid && (sts_i.tag_rd == tag_i);

  // The used way goes to the top; ways above its old rank drop by one.
  always_comb begin
    if (is_target_i)              rank_new_o = top_rank_i;
    else if (rank_o > old_rank_i) rank_new_o = rank_o - 8'd1;
    else                          rank_new_o = rank_o;
  end

endmodule

>>> hdl/set_assoc_writeback_cache_lru.sv
// Top level: sequencer of the set-associative write-back LRU word cache.
//
//  channel  | dir | handshake                 | content
//  s_axis   | in  | s_axis_tvalid/tready      | tuser: req_type; tdata: address, store, fill
//  m_axis   | out | m_axis_tvalid/tready      | tuser: action; tdata: start, size, data; tlast
//  cfg      | in  | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One word at a time. A hit reads and compares each way up to the hitting one, then
// reads and rewrites each rank, all through single-port memories. A miss walks all
// ways, then takes an invalid victim or evicts one, writing back each word of a dirty
// victim, before the rank walk and the fill request. A non-final fill word is stored.
// Reset and any config write other than to CFG_NONE clear the line flags at once;
// no clearing pass. Results stall in the output register.
module set_assoc_writeback_cache_lru import sawc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // word_address, store_value, fill_word
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // range_start, range_size, data_word, zero pad
  output logic [2:0]  m_axis_tuser,   // action
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i
);

  state_e state_q, state_d;
  logic [2:0] lwl_q;
  logic [3:0] scl_q;
  logic [8:0] wc_q;

  logic [1:0]  req_q;
  logic [15:0] addr_q;
  logic [31:0] sval_q, fword_q;
  logic        pend_q, pend_d, pwr_q, pwr_d;
  logic [4:0]  fcnt_q, fcnt_d;
  logic [15:0] paddr_q, paddr_d, vaddr_q, vaddr_d;
  logic [31:0] pval_q, pval_d;
  logic [7:0]  pline_q, pline_d, base_q, base_d, tline_q, tline_d, told_q, told_d;
  logic [8:0]  way_q, way_d;
  logic        hit_q, hit_d, invf_q, invf_d, lruf_q, lruf_d;
  logic [7:0]  invl_q, invl_d, invr_q, invr_d, lrul_q, lrul_d;

  logic        ov_q;
  logic [2:0]  oact_q;
  logic [15:0] ostart_q;
  logic [4:0]  osize_q;
  logic [31:0] odata_q;
  logic        olast_q;

  logic        em;
  act_e        em_act;
  logic [15:0] em_start;
  logic [4:0]  em_size;
  logic [31:0] em_data;
  logic        em_last;

  st_ctl_t ctl;
  st_sts_t sts;

  // Effective geometry.
  logic [2:0]  lw;
  logic [3:0]  sc;
  logic [8:0]  cap, ways;
  logic [4:0]  words;
  logic [3:0]  wmask;
  logic [8:0]  smask;
  logic [15:0] shl, tag_c, vaddr_c;
  logic [7:0]  set_c, line_c, rst_rank, top_rank;
  logic [16:0] prod;
  logic [3:0]  off_c, poff_c;
  logic        way_last, wb_last, out_free, accept, w_hit;
  logic [7:0]  w_rank, w_new;

  assign lw    = (lwl_q > 3'd4) ? 3'd4 : lwl_q;
  assign sc    = (scl_q > 4'd8) ? 4'd8 : scl_q;
  assign cap   = 9'd256 >> sc;
  assign ways  = (wc_q == 9'd0) ? 9'd1 : ((wc_q > cap) ? cap : wc_q);
  assign words = 5'd1 << lw;
  assign wmask = 4'((words - 5'd1));
  assign smask = (9'd1 << sc) - 9'd1;
  assign shl   = addr_q >> lw;
  assign set_c = shl[7:0] & smask[7:0];
  assign tag_c = addr_q >> (5'(lw) + 5'(sc));
  assign prod  = set_c * ways;
  assign off_c  = addr_q[3:0] & wmask;
  assign poff_c = paddr_q[3:0] & wmask;
  assign line_c = base_q + way_q[7:0];
  assign rst_rank = 8'(ways - 9'd1 - way_q);
  assign top_rank = 8'(ways - 9'd1);
  assign way_last = (way_q + 9'd1) == ways;
  assign wb_last  = (way_q[4:0] + 5'd1) == words;
  assign vaddr_c  = (sts.tag_rd << (5'(lw) + 5'(sc))) | ({8'd0, set_c} << lw);
  assign out_free = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  sawc_store u_store (.clk_i, .rst_ni, .ctl_i(ctl), .sts_o(sts));

  sawc_way u_way (
    .tag_i(tag_c), .sts_i(sts), .rst_rank_i(rst_rank), .old_rank_i(told_q),
    .top_rank_i(top_rank), .is_target_i(line_c == tline_q),
    .hit_o(w_hit), .rank_o(w_rank), .rank_new_o(w_new)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lwl_q <= 3'd0;
      scl_q <= 4'd0;
      wc_q  <= 9'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LINE_WORDS_LOG2: lwl_q <= cfg_data_i[2:0];
        CFG_SET_COUNT_LOG2:  scl_q <= cfg_data_i[3:0];
        CFG_WAY_COUNT:       wc_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input word capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= s_axis_tuser;
      addr_q  <= s_axis_tdata[15:0];
      sval_q  <= s_axis_tdata[47:16];
      fword_q <= s_axis_tdata[79:48];
    end
  end

  // Sequencer state and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      fcnt_q  <= 5'd0;
      pwr_q   <= 1'b0;
      hit_q   <= 1'b0;
      invf_q  <= 1'b0;
      lruf_q  <= 1'b0;
      way_q   <= 9'd0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      fcnt_q  <= fcnt_d;
      pwr_q   <= pwr_d;
      hit_q   <= hit_d;
      invf_q  <= invf_d;
      lruf_q  <= lruf_d;
      way_q   <= way_d;
    end
  end

  // Payload registers of the sequencer.
  always_ff @(posedge clk_i) begin
    paddr_q <= paddr_d;
    pval_q  <= pval_d;
    pline_q <= pline_d;
    base_q  <= base_d;
    tline_q <= tline_d;
    told_q  <= told_d;
    vaddr_q <= vaddr_d;
    invl_q  <= invl_d;
    invr_q  <= invr_d;
    lrul_q  <= lrul_d;
  end

  // Next state, store control and result selection.
  always_comb begin
    state_d = state_q;
    pend_d = pend_q; fcnt_d = fcnt_q; pwr_d = pwr_q;
    paddr_d = paddr_q; pval_d = pval_q; pline_d = pline_q;
    base_d = base_q; tline_d = tline_q; told_d = told_q; vaddr_d = vaddr_q;
    hit_d = hit_q; invf_d = invf_q; lruf_d = lruf_q; way_d = way_q;
    invl_d = invl_q; invr_d = invr_q; lrul_d = lrul_q;
    ctl = '0;
    ctl.line = tline_q;
    em = 1'b0; em_act = ACT_REFUSED; em_start = addr_q; em_size = 5'd1;
    em_data = 32'd0; em_last = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == REQ_BAD || ((s_axis_tuser == REQ_FILL) != pend_q))
            state_d = ST_REF;
          else if (s_axis_tuser == REQ_FILL) state_d = ST_FWR;
          else state_d = ST_BASE;
        end
      end
      ST_REF: begin
        if (out_free) begin
          em = 1'b1; em_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      // Store one fill word; the last one completes the access.
      ST_FWR: begin
        ctl.data_we = 1'b1;
        ctl.daddr   = {pline_q, fcnt_q[3:0]};
        ctl.data_wd = fword_q;
        fcnt_d = fcnt_q + 5'd1;
        state_d = (fcnt_q + 5'd1 >= words) ? ST_FEM2 : ST_IDLE;
      end
      ST_FEM2: begin
        if (out_free) begin
          em = 1'b1; em_act = ACT_FILL; em_start = paddr_q & ~{12'd0, wmask};
          em_size = words;
          ctl.daddr = {pline_q, poff_c};
          ctl.data_we = pwr_q;
          ctl.data_re = !pwr_q;
          ctl.data_wd = pval_q;
          state_d = ST_FEML;
        end
      end
      ST_FEML: begin
        if (out_free) begin
          em = 1'b1; em_last = 1'b1;
          em_act = pwr_q ? ACT_WR_HIT : ACT_RD_HIT;
          em_start = paddr_q;
          em_data = pwr_q ? pval_q : sts.data_rd;
          pend_d = 1'b0; fcnt_d = 5'd0;
          state_d = ST_IDLE;
        end
      end
      ST_BASE: begin
        base_d = prod[7:0];
        way_d = 9'd0; hit_d = 1'b0; invf_d = 1'b0; lruf_d = 1'b0;
        state_d = ST_SRD;
      end
      ST_SRD: begin
        ctl.line = line_c; ctl.tag_re = 1'b1; ctl.rank_re = 1'b1;
        state_d = ST_SCMP;
      end
      // One way per pass: hit, first invalid way, first rank-0 way.
      ST_SCMP: begin
        ctl.line = line_c;
        if (w_hit) begin
          hit_d = 1'b1; tline_d = line_c; told_d = w_rank; way_d = 9'd0;
          state_d = ST_TRD;
        end else begin
          if (!sts.valid && !invf_q) begin
            invf_d = 1'b1; invl_d = line_c; invr_d = w_rank;
          end
          if (w_rank == 8'd0 && !lruf_q) begin
            lruf_d = 1'b1; lrul_d = line_c;
          end
          way_d = way_q + 9'd1;
          state_d = way_last ? ST_VIC : ST_SRD;
        end
      end
      ST_VIC: begin
        if (invf_q) begin
          tline_d = invl_q; told_d = invr_q; state_d = ST_UPD;
        end else begin
          tline_d = lruf_q ? lrul_q : base_q; told_d = 8'd0; state_d = ST_VTRD;
        end
      end
      ST_VTRD: begin
        ctl.tag_re = 1'b1;
        state_d = ST_VEV;
      end
      ST_VEV: begin
        if (out_free) begin
          em = 1'b1; em_act = sts.dirty ? ACT_EV_DIRTY : ACT_EV_CLEAN;
          em_start = vaddr_c; em_size = words;
          vaddr_d = vaddr_c; way_d = 9'd0;
          state_d = sts.dirty ? ST_WRD : ST_UPD;
        end
      end
      ST_WRD: begin
        ctl.data_re = 1'b1; ctl.daddr = {tline_q, way_q[3:0]};
        state_d = ST_WEM;
      end
      ST_WEM: begin
        if (out_free) begin
          em = 1'b1; em_act = ACT_WB_WORD;
          em_start = vaddr_q + {12'd0, way_q[3:0]};
          em_data = sts.data_rd;
          way_d = way_q + 9'd1;
          state_d = wb_last ? ST_UPD : ST_WRD;
        end
      end
      ST_UPD: begin
        ctl.valid_set = 1'b1; ctl.dirty_we = 1'b1;
        ctl.dirty_wd = (req_q == REQ_WRITE);
        ctl.tag_we = 1'b1; ctl.tag_wd = tag_c;
        way_d = 9'd0;
        state_d = ST_TRD;
      end
      // LRU update walk, one way per read and write.
      ST_TRD: begin
        ctl.line = line_c; ctl.rank_re = 1'b1;
        state_d = ST_TWR;
      end
      ST_TWR: begin
        ctl.line = line_c; ctl.rank_we = 1'b1; ctl.rank_wd = w_new;
        way_d = way_q + 9'd1;
        if (way_last) state_d = hit_q ? ST_HOP : ST_M6;
        else          state_d = ST_TRD;
      end
      ST_HOP: begin
        ctl.daddr = {tline_q, off_c};
        ctl.data_wd = sval_q;
        ctl.data_we = (req_q == REQ_WRITE);
        ctl.data_re = (req_q != REQ_WRITE);
        ctl.dirty_we = (req_q == REQ_WRITE);
        ctl.dirty_wd = 1'b1;
        state_d = ST_HEM;
      end
      ST_HEM: begin
        if (out_free) begin
          em = 1'b1; em_last = 1'b1;
          em_act = (req_q == REQ_WRITE) ? ACT_WR_HIT : ACT_RD_HIT;
          em_data = (req_q == REQ_WRITE) ? sval_q : sts.data_rd;
          state_d = ST_IDLE;
        end
      end
      ST_M6: begin
        if (out_free) begin
          em = 1'b1; em_last = 1'b1; em_act = ACT_FILL_REQ;
          em_start = addr_q & ~{12'd0, wmask}; em_size = words;
          pend_d = 1'b1; fcnt_d = 5'd0; pwr_d = (req_q == REQ_WRITE);
          paddr_d = addr_q; pval_d = sval_q; pline_d = tline_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // A config write to any index but CFG_NONE invalidates all lines and drops a pending fill.
    if (cfg_we_i && cfg_idx_i != CFG_NONE) begin
      ctl.clr = 1'b1;
      pend_d = 1'b0; fcnt_d = 5'd0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (em) ov_q <= 1'b1;
    else if (m_axis_tready) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (em) begin
      oact_q   <= em_act;
      ostart_q <= em_start;
      osize_q  <= em_size;
      odata_q  <= em_data;
      olast_q  <= em_last;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = oact_q;
  assign m_axis_tdata  = {3'd0, odata_q, osize_q, ostart_q};
  assign m_axis_tlast  = olast_q;

`ifndef SYNTH
  a_fcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= words) else $error("fill count beyond line size");
  a_ref_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ACT_REFUSED) |-> m_axis_tlast)
    else $error("refusal not final");
  a_wb_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ACT_WB_WORD) |-> !m_axis_tlast)
    else $error("write-back word marked final");
`endif

endmodule
